>>> rtl/core/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int ADDR_IN_W = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

  // cursor update request from the sequencer
  typedef struct packed {
    logic step;
    logic newline;
  } cur_cmd_t;

endpackage

>>> rtl/core/tcw_in_if.sv
interface tcw_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [tcw_pkg::CHAR_W-1:0]     character;
  logic [tcw_pkg::ADDR_IN_W-1:0]  cell_address;

  modport source (output valid, output command, output character, output cell_address,
                  input ready);
  modport sink   (input valid, input command, input character, input cell_address,
                  output ready);
endinterface

>>> rtl/core/tcw_out_if.sv
interface tcw_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcw_pkg::CELL_W-1:0]     cell_value;
  logic [tcw_pkg::COL_OUT_W-1:0]  cursor_column;
  logic [tcw_pkg::ROW_OUT_W-1:0]  cursor_row;
  logic                           scrolled;

  modport source (output valid, output cell_value, output cursor_column, output cursor_row,
                  output scrolled, input ready);
  modport sink   (input valid, input cell_value, input cursor_column, input cursor_row,
                  input scrolled, output ready);
endinterface

>>> rtl/core/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tcw_cursor.sv
module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcw_pkg::cur_cmd_t                cmd,
  output logic [$clog2(COLUMNS)-1:0]       col,
  output logic [$clog2(ROWS)-1:0]          row,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  idx,
  output logic [$clog2(COLUMNS)-1:0]       nxt_col,
  output logic [$clog2(ROWS)-1:0]          nxt_row,
  output logic                             scroll
);

  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int AW        = $clog2(COLUMNS*ROWS);
  localparam int LAST_BASE = (ROWS-1)*COLUMNS;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [AW-1:0] base_r, base_nxt;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          wrap;

  always_comb begin
    col_inc = {1'b0, col_r} + (CW+1)'(1);
    row_inc = {1'b0, row_r} + (RW+1)'(1);
    wrap    = cmd.newline || (col_inc == (CW+1)'(COLUMNS));
    scroll  = wrap && (row_inc == (RW+1)'(ROWS));
    nxt_col = wrap ? '0 : col_inc[CW-1:0];
    if (scroll) begin
      nxt_row  = RW'(ROWS-1);
      base_nxt = AW'(LAST_BASE);
    end else if (wrap) begin
      nxt_row  = row_inc[RW-1:0];
      base_nxt = base_r + AW'(COLUMNS);
    end else begin
      nxt_row  = row_r;
      base_nxt = base_r;
    end
  end

  // base_r tracks row*COLUMNS so the cell index is one add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
    end else if (cmd.step) begin
      col_r  <= nxt_col;
      row_r  <= nxt_row;
      base_r <= base_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;
  assign idx = base_r + AW'(col_r);

endmodule

>>> rtl/core/text_console_writer.sv
// Text console over a COLUMNS x ROWS screen of 16-bit cells (attribute byte high,
// character byte low) held in one single-port-write, registered-read memory. After
// reset the block sweeps all COLUMNS*ROWS cells (2000 by default) to blank (space,
// attribute 0x07), one cell a cycle, before it takes its first word. A read or a
// put first reads the memory as the word is accepted, then does any write-back and
// registers the result once the result register has room. A put that scrolls then
// holds off the input while every cell is copied up one row through the memory port
// and the bottom row is blanked with spaces, keeping its attributes. The result
// register lets the next word be accepted while a result still waits to be taken.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tcw_in_if.sink      in_ch,
  tcw_out_if.source   out_ch
);

  localparam int CELLS     = COLUMNS*ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int SW        = AW + 1;
  localparam int LAST_BASE = (ROWS-1)*COLUMNS;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_SCROLL} state_t;

  state_t                         state_r, state_nxt;
  logic [SW-1:0]                  sweep_r, sweep_nxt;
  logic                           wr_v_r, wr_v_nxt;
  logic [AW-1:0]                  wr_addr_r, wr_addr_nxt;
  logic                           wr_blank_r, wr_blank_nxt;
  logic                           cmd_r, cmd_nxt;
  logic [tcw_pkg::CHAR_W-1:0]     ch_r, ch_nxt;
  logic [tcw_pkg::ADDR_IN_W-1:0]  addr_r, addr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [tcw_pkg::CELL_W-1:0]     out_value_r, out_value_nxt;
  logic [tcw_pkg::COL_OUT_W-1:0]  out_col_r, out_col_nxt;
  logic [tcw_pkg::ROW_OUT_W-1:0]  out_row_r, out_row_nxt;
  logic                           out_scr_r, out_scr_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_wdata, ram_rdata;

  tcw_pkg::cur_cmd_t              cur_cmd;
  logic [CW-1:0]                  cur_col, nxt_col;
  logic [RW-1:0]                  cur_row, nxt_row;
  logic [AW-1:0]                  cur_idx;
  logic                           cur_scroll;

  logic                           accept, out_free, done, step, is_nl, read_ok;
  logic [AW-1:0]                  sweep_lo, scroll_src;
  logic [tcw_pkg::CELL_W-1:0]     put_value;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cur_cmd),
    .col     (cur_col),
    .row     (cur_row),
    .idx     (cur_idx),
    .nxt_col (nxt_col),
    .nxt_row (nxt_row),
    .scroll  (cur_scroll)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign done        = (state_r == S_EXEC) && out_free;
  assign step        = done && (cmd_r == tcw_pkg::CMD_PUT);
  assign is_nl       = (ch_r == tcw_pkg::NEWLINE_CHAR);
  assign read_ok     = 32'(addr_r) < 32'(CELLS);
  assign put_value   = {ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], ch_r};
  assign sweep_lo    = sweep_r[AW-1:0];

  always_comb begin
    cur_cmd.step    = step;
    cur_cmd.newline = is_nl;
  end

  // scroll copies cell i+COLUMNS to i, bottom row reads itself and gets blanked
  assign scroll_src = (sweep_lo < AW'(LAST_BASE)) ? sweep_lo + AW'(COLUMNS) : sweep_lo;

  // memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = put_value;
    ram_raddr = cur_idx;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_lo;
        ram_wdata = tcw_pkg::BLANK_CELL;
      end
      S_IDLE: begin
        ram_raddr = (in_ch.command == tcw_pkg::CMD_READ) ? AW'(in_ch.cell_address)
                                                           : cur_idx;
      end
      S_EXEC: begin
        ram_raddr = (cmd_r == tcw_pkg::CMD_READ) ? AW'(addr_r) : cur_idx;
        ram_we    = step && !is_nl;
      end
      S_SCROLL: begin
        ram_raddr = scroll_src;
        ram_we    = wr_v_r;
        ram_waddr = wr_addr_r;
        ram_wdata = wr_blank_r
                  ? {ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::SPACE_CHAR}
                  : ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer and result register
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    wr_v_nxt      = 1'b0;
    wr_addr_nxt   = sweep_lo;
    wr_blank_nxt  = sweep_lo >= AW'(LAST_BASE);
    cmd_nxt       = cmd_r;
    ch_nxt        = ch_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_scr_nxt   = out_scr_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sweep_r == SW'(CELLS-1)) begin
          sweep_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + SW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_ch.command;
          ch_nxt    = in_ch.character;
          addr_nxt  = in_ch.cell_address;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          out_valid_nxt = 1'b1;
          if (cmd_r == tcw_pkg::CMD_READ) begin
            out_value_nxt = read_ok ? ram_rdata : '0;
            out_col_nxt   = tcw_pkg::COL_OUT_W'(cur_col);
            out_row_nxt   = tcw_pkg::ROW_OUT_W'(cur_row);
            out_scr_nxt   = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            out_value_nxt = is_nl ? '0 : put_value;
            out_col_nxt   = tcw_pkg::COL_OUT_W'(nxt_col);
            out_row_nxt   = tcw_pkg::ROW_OUT_W'(nxt_row);
            out_scr_nxt   = cur_scroll;
            sweep_nxt     = '0;
            state_nxt     = cur_scroll ? S_SCROLL : S_IDLE;
          end
        end
      end
      S_SCROLL: begin
        if (sweep_r != SW'(CELLS)) begin
          sweep_nxt = sweep_r + SW'(1);
          wr_v_nxt  = 1'b1;
        end else if (!wr_v_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      wr_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      wr_v_r      <= wr_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wr_addr_r   <= wr_addr_nxt;
    wr_blank_r  <= wr_blank_nxt;
    cmd_r       <= cmd_nxt;
    ch_r        <= ch_nxt;
    addr_r      <= addr_nxt;
    out_value_r <= out_value_nxt;
    out_col_r   <= out_col_nxt;
    out_row_r   <= out_row_nxt;
    out_scr_r   <= out_scr_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_value    = out_value_r;
  assign out_ch.cursor_column = out_col_r;
  assign out_ch.cursor_row    = out_row_r;
  assign out_ch.scrolled      = out_scr_r;

  a_step_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !out_free) |=> (state_r == S_EXEC && out_valid_r))
    else $error("result register overrun");

  a_scroll_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cur_scroll) |=> (state_r == S_SCROLL && sweep_r == '0 && !wr_v_r))
    else $error("scroll sweep not started");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (cur_col == '0 && cur_row == RW'(ROWS-1)))
    else $error("cursor not parked during scroll");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r <= SW'(CELLS))
    else $error("sweep counter past end");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("memory write while idle");

endmodule

>>> dv/tcw_console_checker.sv
module tcw_console_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tcw_in_if    in_mon,
  tcw_out_if   out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   scroll_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [CELL_W-1:0]    value;
    logic [COL_OUT_W-1:0] column;
    logic [ROW_OUT_W-1:0] row;
    logic                 scrolled;
  } console_word_t;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  console_word_t     words_due [$];
  console_word_t     got_word;
  console_word_t     want_word;
  logic              bad_word;
  int                n_bad;
  int                n_scroll;

  // advances the screen copy by one input word, returns the word the block should give
  function automatic console_word_t console_apply(logic cmd, logic [CHAR_W-1:0] ch,
                                                  logic [ADDR_IN_W-1:0] addr);
    console_word_t w;
    int unsigned   pos;
    w = '0;
    if (cmd == CMD_READ) begin
      if (addr < CELLS) w.value = screen[addr];
    end else begin
      if (ch == NEWLINE_CHAR) begin
        cur_col = 0;
        cur_row++;
      end else begin
        pos = cur_row * COLUMNS + cur_col;
        if (pos < CELLS) begin
          // attribute byte stays, character byte replaced
          w.value = {screen[pos][CELL_W-1:CHAR_W], ch};
          screen[pos] = w.value;
        end
        cur_col++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++)
          screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
          screen[i] = {screen[i][CELL_W-1:CHAR_W], SPACE_CHAR};
        cur_col    = 0;
        cur_row    = ROWS - 1;
        w.scrolled = 1'b1;
      end
    end
    w.column = COL_OUT_W'(cur_col);
    w.row    = ROW_OUT_W'(cur_row);
    return w;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++)
        screen[i] = BLANK_CELL;
      cur_col = 0;
      cur_row = 0;
      words_due.delete();
      n_bad        = 0;
      n_scroll     = 0;
      outstanding  <= 0;
      mismatches   <= 0;
      scroll_count <= 0;
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got_word = {out_mon.cell_value, out_mon.cursor_column, out_mon.cursor_row,
                    out_mon.scrolled};
        if (words_due.size() == 0) begin
          $display("%0t: result word with none expected: value %h col %0d row %0d scrolled %b",
                   $time, got_word.value, got_word.column, got_word.row, got_word.scrolled);
          n_bad++;
        end else begin
          want_word = words_due.pop_front();
          bad_word  = 1'b0;
          if (got_word.value !== want_word.value) begin
            $display("%0t: cell_value expected %h actual %h",
                     $time, want_word.value, got_word.value);
            bad_word = 1'b1;
          end
          if (got_word.column !== want_word.column) begin
            $display("%0t: cursor_column expected %0d actual %0d",
                     $time, want_word.column, got_word.column);
            bad_word = 1'b1;
          end
          if (got_word.row !== want_word.row) begin
            $display("%0t: cursor_row expected %0d actual %0d",
                     $time, want_word.row, got_word.row);
            bad_word = 1'b1;
          end
          if (got_word.scrolled !== want_word.scrolled) begin
            $display("%0t: scrolled expected %b actual %b",
                     $time, want_word.scrolled, got_word.scrolled);
            bad_word = 1'b1;
          end
          if (bad_word) n_bad++;
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        want_word = console_apply(in_mon.command, in_mon.character, in_mon.cell_address);
        words_due.push_back(want_word);
        if (want_word.scrolled) n_scroll++;
      end
      outstanding  <= words_due.size();
      mismatches   <= n_bad;
      scroll_count <= n_scroll;
    end
  end

endmodule

>>> dv/tb_text_console_writer.sv
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 5;
  localparam int WORDS_PER_PHASE = 286;
  localparam int DRAIN_CYCLES    = 2100;

  logic clk;
  logic rst_n;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  int mismatches;
  int outstanding;
  int scroll_count;

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_req;
  int hold_done = 0;
  int hold_left = 0;
  int n_reads;
  int n_chars;
  int n_newlines;

  int tx_plan [PHASES] = '{0, 71, 0, 24, 0};
  int rx_plan [PHASES] = '{0, 0, 71, 24, 0};

  text_console_writer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tcw_console_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .scroll_count (scroll_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("** text_console_writer: FAILED **");
    $finish;
  end

  // result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_left    <= HOLD_CYCLES;
      hold_done    <= hold_done + 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_word(input logic cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_IN_W-1:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.character    <= ch;
    in_ch.cell_address <= addr;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (cmd == CMD_READ) n_reads++;
    else if (ch == NEWLINE_CHAR) n_newlines++;
    else n_chars++;
  endtask

  initial begin
    logic [CHAR_W-1:0]    ch;
    logic [ADDR_IN_W-1:0] addr;
    int                   pick;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_PUT;
    in_ch.character    <= '0;
    in_ch.cell_address <= '0;
    tx_idle_pct  = 0;
    rx_stall_pct <= 0;
    hold_req     <= 0;
    n_reads      = 0;
    n_chars      = 0;
    n_newlines   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, zero byte, newline, read extremes and out of range
    send_word(CMD_PUT,  8'h00,        11'd0);
    send_word(CMD_PUT,  8'hFF,        11'd2047);
    send_word(CMD_PUT,  8'h41,        11'd0);
    send_word(CMD_PUT,  8'h7F,        11'd0);
    send_word(CMD_PUT,  8'h80,        11'd0);
    send_word(CMD_PUT,  SPACE_CHAR,   11'd0);
    send_word(CMD_READ, 8'h00,        11'd0);
    send_word(CMD_READ, 8'hFF,        11'd1);
    send_word(CMD_READ, 8'h0A,        11'd2);
    send_word(CMD_READ, 8'h00,        11'd4);
    send_word(CMD_READ, 8'h00,        11'd6);
    send_word(CMD_READ, 8'h00,        11'd1999);
    send_word(CMD_READ, 8'h00,        11'd2000);
    send_word(CMD_READ, 8'h00,        11'd2047);
    send_word(CMD_READ, 8'h00,        11'd1024);
    send_word(CMD_READ, 8'h00,        11'd1023);
    send_word(CMD_PUT,  NEWLINE_CHAR, 11'd0);
    send_word(CMD_PUT,  8'h78,        11'd0);
    send_word(CMD_READ, 8'h00,        11'd80);
    send_word(CMD_PUT,  NEWLINE_CHAR, 11'd0);
    send_word(CMD_PUT,  NEWLINE_CHAR, 11'd0);
    send_word(CMD_READ, 8'h00,        11'd81);
    send_word(CMD_READ, 8'h00,        11'd160);

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_idle_pct  = tx_plan[ph];
      rx_stall_pct <= rx_plan[ph];
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // output held off while words keep coming, so the input backs up
        if ((ph == 2 && k == 0) || (ph == 4 && k == 150)) hold_req <= hold_req + 1;
        pick = $urandom_range(99);
        if (pick < 25) begin
          addr = ($urandom_range(9) == 0) ? ADDR_IN_W'($urandom_range(2047, 2000))
                                          : ADDR_IN_W'($urandom_range(1999));
          send_word(CMD_READ, CHAR_W'($urandom), addr);
        end else begin
          ch = ($urandom_range(99) < 7) ? NEWLINE_CHAR : CHAR_W'($urandom_range(255));
          send_word(CMD_PUT, ch, ADDR_IN_W'($urandom));
        end
      end
      // let every expected result word come out before the next phase
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (outstanding != 0) @(posedge clk);
    end

    rx_stall_pct <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d characters, %0d newlines and %0d cell reads",
             n_chars, n_newlines, n_reads);
    $display("with %0d scrolls and %0d long output hold-offs", scroll_count, hold_done);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** text_console_writer: PASSED **");
    end else begin
      $display("** text_console_writer: FAILED **");
    end
    $finish;
  end

endmodule
